// ===== hw/rtl/vowel_quantity_mark_transcoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vowel quantity mark transcoder
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef VOWEL_QUANTITY_MARK_TRANSCODER_UNIT_ASSERT_SVH
`define VOWEL_QUANTITY_MARK_TRANSCODER_UNIT_ASSERT_SVH

// same-cycle implication, masked while reset is asserted
`define VQMT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vqmt assertion failed");

// next-cycle implication, masked while reset is asserted
`define VQMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vqmt assertion failed");

// next-cycle implication, always active (for reset behavior)
`define VQMT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vqmt assertion failed");

`endif

// ===== hw/rtl/vqmt_pkg.sv =====
// ----------------------------------------------------------------------------
// vqmt_pkg
// Types, byte codes and letter tables of the vowel quantity mark transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vqmt_pkg;

    // marker bytes
    localparam logic [7:0] C_UNDERSCORE = 8'h5F;
    localparam logic [7:0] C_CARET      = 8'h5E;

    // UTF-8 lead bytes of the Latin Extended-A letters used here
    localparam logic [7:0] C_LEAD_C4 = 8'hC4;
    localparam logic [7:0] C_LEAD_C5 = 8'hC5;

    // number of plain vowels in the table
    localparam int unsigned C_NUM_VOWELS = 10;

    // position of a vowel in "aeiouAEIOU"
    typedef logic [3:0] t_vidx;

    typedef struct packed {
        logic  hit;
        t_vidx idx;
    } t_vpos;

    // one output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_last;
    } t_out_word;

    // words produced by one input word
    typedef struct packed {
        logic [1:0] cnt;
        t_out_word  w0;
        t_out_word  w1;
    } t_dec;

    // plain vowel byte for a table position
    function automatic logic [7:0] f_vowel_byte(input t_vidx idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h61;
            4'd1:    b = 8'h65;
            4'd2:    b = 8'h69;
            4'd3:    b = 8'h6F;
            4'd4:    b = 8'h75;
            4'd5:    b = 8'h41;
            4'd6:    b = 8'h45;
            4'd7:    b = 8'h49;
            4'd8:    b = 8'h4F;
            4'd9:    b = 8'h55;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // table position of a byte, if it is a plain vowel
    function automatic t_vpos f_vowel_pos(input logic [7:0] b);
        t_vpos p;
        p.hit = 1'b1;
        case (b)
            8'h61:   p.idx = 4'd0;
            8'h65:   p.idx = 4'd1;
            8'h69:   p.idx = 4'd2;
            8'h6F:   p.idx = 4'd3;
            8'h75:   p.idx = 4'd4;
            8'h41:   p.idx = 4'd5;
            8'h45:   p.idx = 4'd6;
            8'h49:   p.idx = 4'd7;
            8'h4F:   p.idx = 4'd8;
            8'h55:   p.idx = 4'd9;
            default: begin
                p.hit = 1'b0;
                p.idx = 4'd0;
            end
        endcase
        return p;
    endfunction

    // lead byte, shared by macron and breve forms: o and u sit in the C5 block
    function automatic logic [7:0] f_mark_lead(input t_vidx idx);
        logic [7:0] b;
        case (idx) inside
            4'd3, 4'd4, 4'd8, 4'd9: b = C_LEAD_C5;
            default:                b = C_LEAD_C4;
        endcase
        return b;
    endfunction

    // trail byte of the macron letter
    function automatic logic [7:0] f_macron_trail(input t_vidx idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h81;
            4'd1:    b = 8'h93;
            4'd2:    b = 8'hAB;
            4'd3:    b = 8'h8D;
            4'd4:    b = 8'hAB;
            4'd5:    b = 8'h80;
            4'd6:    b = 8'h92;
            4'd7:    b = 8'hAA;
            4'd8:    b = 8'h8C;
            4'd9:    b = 8'hAA;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // trail byte of the breve letter
    function automatic logic [7:0] f_breve_trail(input t_vidx idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h83;
            4'd1:    b = 8'h95;
            4'd2:    b = 8'hAD;
            4'd3:    b = 8'h8F;
            4'd4:    b = 8'hAD;
            4'd5:    b = 8'h82;
            4'd6:    b = 8'h94;
            4'd7:    b = 8'hAC;
            4'd8:    b = 8'h8E;
            4'd9:    b = 8'hAC;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vqmt_if.sv =====
// ----------------------------------------------------------------------------
// vqmt_in_if / vqmt_out_if
// Valid/ready channels carrying text words in and UTF-8 words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface vqmt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface vqmt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;

    modport source (output valid, output out_byte, output run_last, output text_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input text_last,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vqmt_mark_decode.sv =====
// ----------------------------------------------------------------------------
// vqmt_mark_decode
// Holds the pending vowel and text state and maps one input word to up to
// two output words.
// ----------------------------------------------------------------------------
`default_nettype none

module vqmt_mark_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    input  wire logic          i_breve,
    output vqmt_pkg::t_dec     o_dec
);
    import vqmt_pkg::*;

    logic  r_held;
    t_vidx r_idx;
    logic  r_started;
    logic  n_held;
    t_vidx n_idx;
    logic  n_started;

    logic       held_now;
    logic       is_mark;
    t_vpos      pos;
    logic [1:0] v_cnt;
    logic [7:0] v_b0;
    logic [7:0] v_b1;
    logic       v_held;
    t_vidx      v_idx;
    logic       v_started;

    // word mapping for the current input word
    always_comb begin
        held_now  = r_held && (r_idx < t_vidx'(C_NUM_VOWELS));
        is_mark   = ((i_byte == C_UNDERSCORE) || (i_byte == C_CARET)) && r_started;
        pos       = f_vowel_pos(i_byte);
        v_cnt     = 2'd0;
        v_b0      = 8'h00;
        v_b1      = 8'h00;
        v_held    = r_held;
        v_idx     = r_idx;
        v_started = r_started;

        if (is_mark) begin
            // underscore, or caret in breve mode, after a held vowel marks it; otherwise the marker is dropped
            if (held_now && ((i_byte == C_UNDERSCORE) || i_breve)) begin
                v_b0   = f_mark_lead(r_idx);
                v_b1   = (i_byte == C_UNDERSCORE) ? f_macron_trail(r_idx)
                                                  : f_breve_trail(r_idx);
                v_cnt  = 2'd2;
                v_held = 1'b0;
                v_idx  = '0;
            end
        end else begin
            // release held vowel, then hold or pass the new byte
            if (held_now) begin
                v_b0   = f_vowel_byte(r_idx);
                v_cnt  = 2'd1;
                v_held = 1'b0;
                v_idx  = '0;
            end
            if (pos.hit) begin
                v_held = 1'b1;
                v_idx  = pos.idx;
            end else if (v_cnt == 2'd0) begin
                v_b0  = i_byte;
                v_cnt = 2'd1;
            end else begin
                v_b1  = i_byte;
                v_cnt = 2'd2;
            end
            v_started = 1'b1;
        end

        // end of text: flush and clear
        if (i_last) begin
            if (v_held && (v_idx < t_vidx'(C_NUM_VOWELS))) begin
                if (v_cnt == 2'd0) begin
                    v_b0  = f_vowel_byte(v_idx);
                    v_cnt = 2'd1;
                end else if (v_cnt == 2'd1) begin
                    v_b1  = f_vowel_byte(v_idx);
                    v_cnt = 2'd2;
                end
            end
            v_held    = 1'b0;
            v_idx     = '0;
            v_started = 1'b0;
        end

        o_dec.cnt          = v_cnt;
        o_dec.w0.out_byte  = v_b0;
        o_dec.w0.run_last  = (v_cnt == 2'd1);
        o_dec.w0.text_last = (v_cnt == 2'd1) && i_last;
        o_dec.w1.out_byte  = v_b1;
        o_dec.w1.run_last  = (v_cnt == 2'd2);
        o_dec.w1.text_last = (v_cnt == 2'd2) && i_last;

        n_held    = i_fire ? v_held    : r_held;
        n_idx     = i_fire ? v_idx     : r_idx;
        n_started = i_fire ? v_started : r_started;
    end

    // text state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= 1'b0;
            r_idx     <= '0;
            r_started <= 1'b0;
        end else begin
            r_held    <= n_held;
            r_idx     <= n_idx;
            r_started <= n_started;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vqmt_out_queue.sv =====
// ----------------------------------------------------------------------------
// vqmt_out_queue
// Two-slot result register: takes up to two words per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module vqmt_out_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  vqmt_pkg::t_dec       i_dec,
    output logic [1:0]           o_free,
    vqmt_out_if.source           o_out
);
    import vqmt_pkg::*;

    t_out_word  r_slot0;
    t_out_word  r_slot1;
    logic [1:0] r_cnt;
    t_out_word  n_slot0;
    t_out_word  n_slot1;
    logic [1:0] n_cnt;

    logic       pop;
    logic [1:0] cnt_after_pop;

    assign pop    = (r_cnt != 2'd0) && o_out.ready;
    assign o_free = 2'd2 - r_cnt + {1'b0, pop};

    // drain slot 0, shift, then append new words behind what remains
    always_comb begin
        n_slot0       = pop ? r_slot1 : r_slot0;
        n_slot1       = r_slot1;
        cnt_after_pop = r_cnt - {1'b0, pop};
        n_cnt         = cnt_after_pop;
        // a push with no words leaves the slots alone (they may be full)
        if (i_push && (i_dec.cnt != 2'd0)) begin
            if (cnt_after_pop == 2'd0) begin
                n_slot0 = i_dec.w0;
                n_slot1 = i_dec.w1;
            end else begin
                n_slot1 = i_dec.w0;
            end
            n_cnt = cnt_after_pop + i_dec.cnt;
        end
    end

    // slot count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.out_byte  = r_slot0.out_byte;
    assign o_out.run_last  = r_slot0.run_last;
    assign o_out.text_last = r_slot0.text_last;

endmodule

`default_nettype wire

// ===== hw/rtl/vowel_quantity_mark_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// vowel_quantity_mark_transcoder_unit
// ASCII to UTF-8 transcoder turning underscore/caret marks after a vowel
// into macron or breve letters.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : text words (in_byte, end_of_text), valid/ready.
//   o_out  : UTF-8 words (out_byte, run_last, text_last), valid/ready.
//   i_cfg_we / i_cfg_wdata : writes breve_mode; write only while idle.
// Path: an accepted word is registered in the input register, then mapped
//   and written into the two-slot result register once its words fit; the
//   output port offers the oldest word of the result register.
// Throughput: one input word per cycle while each yields at most one output
//   word and the receiver does not stall; words yielding two output words
//   slow the input, as the single-word output port drains the result register.
// Reset (synchronous, active low) empties the pipeline, drops any held
//   vowel and clears breve_mode.
// When the receiver stalls, output words wait in the result register; the
//   input keeps being taken until the pending word no longer fits.
// ----------------------------------------------------------------------------
`default_nettype none

module vowel_quantity_mark_transcoder_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vqmt_in_if.sink   i_in,
    vqmt_out_if.source o_out,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata
);
    import vqmt_pkg::*;

    logic       r_breve;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    t_dec       dec;
    logic [1:0] free;
    logic       fire;
    logic       accept;

    // mapped words move on when they fit in the result register
    assign fire       = r_in_vld && (dec.cnt <= free);
    assign i_in.ready = !r_in_vld || fire;
    assign accept     = i_in.valid && i_in.ready;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_breve <= 1'b0;
        end else if (i_cfg_we) begin
            r_breve <= i_cfg_wdata;
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.end_of_text;
        end
    end

    vqmt_mark_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_breve (r_breve),
        .o_dec   (dec)
    );

    vqmt_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_dec   (dec),
        .o_free  (free),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/vqmt_chk.sv =====
// ----------------------------------------------------------------------------
// vqmt_chk
// Port-level checks of the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vowel_quantity_mark_transcoder_unit_assert.svh"

module vqmt_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_run_last,
    input wire logic       i_out_text_last
);

    // a stalled output word stays offered
    `VQMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a stalled output word keeps its byte
    `VQMT_ASSERT_NEXT(a_out_keep, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_byte))

    // the end of a text always closes the run of its input word
    `VQMT_ASSERT_IMPLY(a_text_run, i_clk, i_rst_n, i_out_valid && i_out_text_last, i_out_run_last)

    // input only backs up behind pending output words
    `VQMT_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // reset empties the result register
    `VQMT_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind vowel_quantity_mark_transcoder_unit vqmt_chk u_vqmt_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_out_run_last  (o_out.run_last),
    .i_out_text_last (o_out.text_last)
);

`default_nettype wire

// ===== tb/tb_vowel_quantity_mark_transcoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_vowel_quantity_mark_transcoder_unit
// Self-checking bench for the vowel quantity mark transcoder. A clocked
// driver feeds text words in bursts from a pending queue. A clocked monitor
// computes the UTF-8 words each accepted text word must yield and checks
// every output word against the oldest of them. The receiver stalls on its
// own pattern. breve_mode is rewritten between phases, only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vowel_quantity_mark_transcoder_unit;
    import vqmt_pkg::*;

    localparam int DRAIN_CYCLES = 8;     // pipeline latency plus margin
    localparam int WDOG_LIMIT   = 2000;  // cycles with no word moving
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_WORDS  = 150;

    // plain vowels "aeiouAEIOU" and the UTF-8 bytes of their marked forms
    localparam logic [7:0] PLAIN_V [10] = '{8'h61, 8'h65, 8'h69, 8'h6F, 8'h75,
                                            8'h41, 8'h45, 8'h49, 8'h4F, 8'h55};
    localparam logic [7:0] MARK_LEAD [10] = '{C_LEAD_C4, C_LEAD_C4, C_LEAD_C4,
                                              C_LEAD_C5, C_LEAD_C5, C_LEAD_C4,
                                              C_LEAD_C4, C_LEAD_C4, C_LEAD_C5,
                                              C_LEAD_C5};
    localparam logic [7:0] MACRON_TRAIL [10] = '{8'h81, 8'h93, 8'hAB, 8'h8D, 8'hAB,
                                                 8'h80, 8'h92, 8'hAA, 8'h8C, 8'hAA};
    localparam logic [7:0] BREVE_TRAIL [10] = '{8'h83, 8'h95, 8'hAD, 8'h8F, 8'hAD,
                                                8'h82, 8'h94, 8'hAC, 8'h8E, 8'hAC};

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } t_text_word;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    vqmt_in_if  in_ch ();
    vqmt_out_if out_ch ();

    vowel_quantity_mark_transcoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    t_text_word pending_text [$];
    t_out_word  expected_utf8 [$];

    // transcoder state as the bench sees it
    logic       mk_breve;
    logic       mk_held;
    logic [3:0] mk_idx;
    logic       mk_started;

    int  err_cnt;
    int  quiet_cycles;
    logic in_took;
    bit  tx_steady;
    int  burst_left;
    int  gap_left;
    int  rx_mode;
    int  rx_tick;
    int  stall_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected UTF-8 words for one accepted text word; updates the state
    function automatic void transcode_word(input logic [7:0] ch, input logic eot);
        logic [7:0] bytes [$];
        t_out_word  w;
        int         pos;
        pos = -1;
        if ((ch == C_UNDERSCORE || ch == C_CARET) && mk_started) begin
            // underscore, or caret in breve mode, after a held vowel marks it; otherwise the marker is dropped
            if (mk_held) begin
                if (ch == C_UNDERSCORE) begin
                    bytes.push_back(MARK_LEAD[mk_idx]);
                    bytes.push_back(MACRON_TRAIL[mk_idx]);
                    mk_held = 1'b0;
                end else if (mk_breve) begin
                    bytes.push_back(MARK_LEAD[mk_idx]);
                    bytes.push_back(BREVE_TRAIL[mk_idx]);
                    mk_held = 1'b0;
                end
            end
        end else begin
            if (mk_held) begin
                bytes.push_back(PLAIN_V[mk_idx]);
                mk_held = 1'b0;
            end
            for (int i = 0; i < 10; i++) begin
                if (PLAIN_V[i] == ch && pos < 0) pos = i;
            end
            if (pos >= 0) begin
                mk_held = 1'b1;
                mk_idx  = 4'(pos);
            end else begin
                bytes.push_back(ch);
            end
            mk_started = 1'b1;
        end
        // end of text flushes the held vowel and clears the text state
        if (eot) begin
            if (mk_held) bytes.push_back(PLAIN_V[mk_idx]);
            mk_held    = 1'b0;
            mk_started = 1'b0;
        end
        if (!mk_held) mk_idx = 4'd0;
        foreach (bytes[i]) begin
            w.out_byte  = bytes[i];
            w.run_last  = (i == bytes.size() - 1);
            w.text_last = (i == bytes.size() - 1) && eot;
            expected_utf8.push_back(w);
        end
    endfunction

    task automatic report_err(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("mismatch: %s", msg);
    endtask

    // monitor: check output words, predict from accepted text words
    always @(posedge i_clk) begin : monitor
        t_out_word got;
        t_out_word want;
        in_took <= in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.out_byte  = out_ch.out_byte;
                got.run_last  = out_ch.run_last;
                got.text_last = out_ch.text_last;
                if (expected_utf8.size() == 0) begin
                    report_err($sformatf("unexpected word byte=%h run_last=%b text_last=%b",
                                         got.out_byte, got.run_last, got.text_last));
                end else begin
                    want = expected_utf8.pop_front();
                    if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                        got.text_last !== want.text_last)
                        report_err($sformatf(
                            "exp byte=%h run_last=%b text_last=%b, got %h %b %b",
                            want.out_byte, want.run_last, want.text_last,
                            got.out_byte, got.run_last, got.text_last));
                end
            end
            if (in_ch.valid && in_ch.ready)
                transcode_word(in_ch.in_byte, in_ch.end_of_text);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // driver: text words in bursts separated by random gaps, no gaps while tx_steady
    always @(negedge i_clk) begin : drive_text
        t_text_word w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_took) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_text.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else begin
                w = pending_text.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.in_byte     <= w.ch;
                in_ch.end_of_text <= w.eot;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = tx_steady ? 0 :
                                 ($urandom_range(0, 7) == 0 ? $urandom_range(10, 20)
                                                            : $urandom_range(0, 4));
                end
            end
        end
    end

    // receiver: mode is redrawn from a tick counter; always ready, random, or long stalls
    always @(negedge i_clk) begin : drive_ready
        logic nxt;
        rx_tick++;
        if (rx_tick % 200 == 0) rx_mode = $urandom_range(0, 2);
        if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b0;
        end else begin
            case (rx_mode)
                0: nxt = 1'b1;
                1: nxt = ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 30);
                    nxt = 1'b1;
                end
            endcase
        end
        out_ch.ready <= nxt;
    end

    task automatic queue_word(input logic [7:0] ch, input logic eot);
        t_text_word w;
        w.ch  = ch;
        w.eot = eot;
        pending_text.push_back(w);
    endtask

    // queue a string; eot marks its last character
    task automatic queue_text(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++)
            queue_word(s[i], eot && (i == s.len() - 1));
    endtask

    // vowels and markers, plus plain text and arbitrary bytes
    task automatic queue_random(input int n);
        int kind;
        logic [7:0] ch;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35)      ch = PLAIN_V[$urandom_range(0, 9)];
            else if (kind < 50) ch = C_UNDERSCORE;
            else if (kind < 62) ch = C_CARET;
            else if (kind < 90) ch = 8'($urandom_range(8'h20, 8'h7E));
            else                ch = 8'($urandom_range(0, 255));
            queue_word(ch, $urandom_range(0, 11) == 0);
        end
    endtask

    // wait for every queued word to be taken and every expected word to arrive
    task automatic wait_idle();
        while (pending_text.size() != 0 || in_ch.valid || expected_utf8.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_breve(input logic v);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        mk_breve = v;
    endtask

    // watchdog
    initial begin
        while (quiet_cycles < WDOG_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = 8'h00;
        in_ch.end_of_text = 1'b0;
        out_ch.ready      = 1'b0;
        mk_breve   = 1'b0;
        mk_held    = 1'b0;
        mk_idx     = 4'd0;
        mk_started = 1'b0;
        err_cnt      = 0;
        quiet_cycles = 0;
        in_took      = 1'b0;
        tx_steady    = 1'b0;
        burst_left   = 0;
        gap_left     = 0;
        rx_mode      = 0;
        rx_tick      = 0;
        stall_left   = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // breve off: marker on empty text, macron, swallowed carets, odd bytes
        set_breve(1'b0);
        queue_text("^a_E^^_xu^z", 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h80, 1'b0);
        queue_text("O", 1'b1);
        queue_text("_", 1'b1);
        queue_text("b_", 1'b1);   // last word yields nothing
        wait_idle();

        // breve on: breve letters, flush on end of text
        set_breve(1'b1);
        queue_text("i^U^", 1'b1);
        queue_text("Ab", 1'b1);
        queue_text("o", 1'b1);
        wait_idle();

        // random phases; each half ends with the sender paused until drained
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_breve(ph < 2 ? ph[0] : 1'($urandom_range(0, 1)));
            tx_steady = (ph == 2);
            queue_random(PHASE_WORDS / 2);
            wait_idle();
            queue_random(PHASE_WORDS - PHASE_WORDS / 2);
            wait_idle();
        end

        if (expected_utf8.size() != 0) report_err("expected words left over");
        if (err_cnt == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/vqmt_pkg.sv
hw/rtl/vqmt_if.sv
hw/rtl/vqmt_mark_decode.sv
hw/rtl/vqmt_out_queue.sv
hw/rtl/vowel_quantity_mark_transcoder_unit.sv
hw/rtl/vqmt_chk.sv
tb/tb_vowel_quantity_mark_transcoder_unit.sv
